@@ rtl/rotated_window_extract_core_assert.svh @@
// ----------------------------------------------------------------------------
// rotated window extract assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ROTATED_WINDOW_EXTRACT_CORE_ASSERT_SVH
`define ROTATED_WINDOW_EXTRACT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside of reset
`define RWE_ASSERT_RST(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);

// property checked on every rising edge, reset included
`define RWE_ASSERT_PLAIN(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RWE_ASSERT_RST(lbl, clk_i, rst_n_i, prop, msg)

`define RWE_ASSERT_PLAIN(lbl, clk_i, prop, msg)

`endif

`endif

@@ rtl/rwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_pkg
// shared types, codes and helpers of the rotated window extract core
// ----------------------------------------------------------------------------
package rwe_pkg;

	// request codes
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_OBSERVE = 1'b1;

	// orientation codes
	localparam logic [1:0] ORIENT_UP    = 2'd0;
	localparam logic [1:0] ORIENT_RIGHT = 2'd1;
	localparam logic [1:0] ORIENT_DOWN  = 2'd2;
	localparam logic [1:0] ORIENT_LEFT  = 2'd3;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_CODE   = 3'd4;
	localparam int CFG_DATA_W = 9;

	// register reset values
	localparam logic [6:0]        RST_MAP_ROWS    = 7'd64;
	localparam logic [6:0]        RST_MAP_COLS    = 7'd64;
	localparam logic [1:0]        RST_VIEW_RADIUS = 2'd3;
	localparam logic              RST_OUTPUT_MODE = 1'b0;
	localparam logic signed [8:0] RST_FILL_CODE   = 9'sd0;

	localparam logic MODE_CLASS = 1'b0;
	localparam logic MODE_RAW   = 1'b1;

	// cell bytes and class codes
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_AT    = 8'd64;
	localparam logic [7:0] CH_F     = 8'd70;
	localparam logic [7:0] CH_A     = 8'd65;
	localparam logic signed [8:0] CLASS_SPACE = 9'sd1;
	localparam logic signed [8:0] CLASS_AT    = 9'sd2;
	localparam logic signed [8:0] CLASS_F     = 9'sd3;
	localparam logic signed [8:0] CLASS_A     = 9'sd4;
	localparam logic [8:0]        CLASS_OFFSET = 9'd92;

	typedef struct packed {
		logic       req_type;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
		logic [7:0] cell_byte;
		logic [5:0] agent_row;
		logic [5:0] agent_col;
		logic [1:0] orientation;
	} in_word_t;

	typedef struct packed {
		logic signed [8:0] cell_value;
		logic [5:0]        obs_index;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic [6:0]        map_rows;
		logic [6:0]        map_cols;
		logic [1:0]        view_radius;
		logic              output_mode;
		logic signed [8:0] fill_code;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic wr_cell;
		logic obs_start;
		logic scan_en;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic issue_last;
		logic s1_busy;
	} dp_status_t;

	function automatic logic signed [8:0] class_of(input logic [7:0] b);
		logic signed [8:0] v;
		case (b)
			CH_SPACE: v = CLASS_SPACE;
			CH_AT:    v = CLASS_AT;
			CH_F:     v = CLASS_F;
			CH_A:     v = CLASS_A;
			default:  v = $signed({1'b0, b} - CLASS_OFFSET);
		endcase
		return v;
	endfunction

endpackage

@@ rtl/rwe_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_cfg_regs
// configuration register file, one write per accepted word
// ----------------------------------------------------------------------------
module rwe_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rwe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rwe_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rwe_pkg::cfg_t                   cfg
);
	import rwe_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_rows    <= RST_MAP_ROWS;
			cfg_q.map_cols    <= RST_MAP_COLS;
			cfg_q.view_radius <= RST_VIEW_RADIUS;
			cfg_q.output_mode <= RST_OUTPUT_MODE;
			cfg_q.fill_code   <= RST_FILL_CODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_ROWS:    cfg_q.map_rows    <= cfg_data[6:0];
				CFG_MAP_COLS:    cfg_q.map_cols    <= cfg_data[6:0];
				CFG_VIEW_RADIUS: cfg_q.view_radius <= cfg_data[1:0];
				CFG_OUTPUT_MODE: cfg_q.output_mode <= cfg_data[0];
				CFG_FILL_CODE:   cfg_q.fill_code   <= $signed(cfg_data[8:0]);
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/rwe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_ctrl
// sequencer: clearing pass, request dispatch and window scan
// ----------------------------------------------------------------------------
module rwe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                req_type,
	output logic                in_ready,
	output rwe_pkg::ctrl_cmd_t  cmd,
	input  rwe_pkg::dp_status_t sts
);
	import rwe_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// hold off while a read of the previous window is still pending
				in_ready = !sts.s1_busy;
				if (in_valid && in_ready) begin
					if (req_type == REQ_WRITE) begin
						cmd.wr_cell = 1'b1;
					end else begin
						cmd.obs_start = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.issue_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ rtl/rwe_datapath.sv @@
`timescale 1ns / 1ps
`include "rotated_window_extract_core_assert.svh"
// ----------------------------------------------------------------------------
// rwe_datapath
// grid memory, window scan counters, read pipeline and output register
// ----------------------------------------------------------------------------
module rwe_datapath #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_RADIUS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rwe_pkg::ctrl_cmd_t  cmd,
	output rwe_pkg::dp_status_t sts,
	input  rwe_pkg::in_word_t   in_word,
	input  rwe_pkg::cfg_t       cfg,
	input  logic                out_ready,
	output logic                out_valid,
	output rwe_pkg::out_word_t  out_word
);
	import rwe_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];

	// clearing pass
	logic [ADDR_W-1:0] clr_addr_q;

	// observe context
	logic [5:0] ar_q, ac_q;
	logic [1:0] orient_q;
	logic [1:0] rad_q;
	logic [6:0] rows_q, cols_q;
	logic [2:0] i_q, j_q;
	logic [5:0] k_q;

	// pipeline
	logic              valid_s1, valid_s2, out_valid_q;
	logic [ADDR_W-1:0] addr_s1;
	logic              inb_s1, inb_s2;
	logic [5:0]        k_s1, k_s2;
	logic              last_s1, last_s2;
	logic [7:0]        rdata_s2;
	out_word_t         out_word_q;

	logic              adv, issue, at_last;
	logic [2:0]        smax, r, c;
	logic signed [7:0] gr, gc;
	logic              inb;
	logic [ADDR_W-1:0] cell_addr, wr_addr, mem_addr;
	logic              wr_in_range, mem_we, mem_re;
	logic [7:0]        mem_wdata;
	logic [6:0]        rows_eff, cols_eff;
	logic [1:0]        rad_eff;
	logic signed [8:0] value_d;

	assign adv     = !out_valid_q || out_ready;
	assign issue   = cmd.scan_en && adv;
	assign smax    = {rad_q, 1'b0};
	assign at_last = (i_q == smax) && (j_q == smax);

	assign sts.clear_done = cmd.clr_step && (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.issue_last = issue && at_last;
	assign sts.s1_busy    = valid_s1;

	assign rows_eff = (int'(cfg.map_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.map_rows;
	assign cols_eff = (int'(cfg.map_cols) > MAX_COLS) ? 7'(MAX_COLS) : cfg.map_cols;
	assign rad_eff  = (int'(cfg.view_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg.view_radius;

	// rotate output position into window-local cell
	always_comb begin
		case (orient_q)
			ORIENT_UP: begin
				r = i_q;
				c = j_q;
			end
			ORIENT_RIGHT: begin
				r = j_q;
				c = smax - i_q;
			end
			ORIENT_DOWN: begin
				r = smax - i_q;
				c = smax - j_q;
			end
			default: begin
				r = smax - j_q;
				c = i_q;
			end
		endcase
	end

	assign gr = $signed({2'b00, ar_q}) - $signed({6'b000000, rad_q}) + $signed({5'b00000, r});
	assign gc = $signed({2'b00, ac_q}) - $signed({6'b000000, rad_q}) + $signed({5'b00000, c});

	assign inb = !gr[7] && (gr[6:0] < rows_q) && !gc[7] && (gc[6:0] < cols_q);

	assign cell_addr = ADDR_W'(gr[6:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(gc[6:0]);

	assign wr_in_range = (int'(in_word.cell_row) < MAX_ROWS) &&
			(int'(in_word.cell_col) < MAX_COLS);
	assign wr_addr = ADDR_W'(in_word.cell_row) * ADDR_W'(MAX_COLS) +
			ADDR_W'(in_word.cell_col);

	// single port: clear, cell write or window read
	assign mem_we    = cmd.clr_step || (cmd.wr_cell && wr_in_range);
	assign mem_re    = adv && valid_s1;
	assign mem_wdata = cmd.clr_step ? CH_SPACE : in_word.cell_byte;
	always_comb begin
		if (cmd.clr_step) begin
			mem_addr = clr_addr_q;
		end else if (cmd.wr_cell) begin
			mem_addr = wr_addr;
		end else begin
			mem_addr = addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_s2 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// latch centre, orientation and map limits, then step the scan
	always_ff @(posedge clk) begin
		if (cmd.obs_start) begin
			ar_q     <= in_word.agent_row;
			ac_q     <= in_word.agent_col;
			orient_q <= in_word.orientation;
			rad_q    <= rad_eff;
			rows_q   <= rows_eff;
			cols_q   <= cols_eff;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
			if (j_q == smax) begin
				j_q <= '0;
				i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_comb begin
		if (!inb_s2) begin
			value_d = cfg.fill_code;
		end else if (cfg.output_mode == MODE_RAW) begin
			value_d = $signed({1'b0, rdata_s2});
		end else begin
			value_d = class_of(rdata_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1               <= cell_addr;
			inb_s1                <= inb;
			k_s1                  <= k_q;
			last_s1               <= at_last;
			inb_s2                <= inb_s1;
			k_s2                  <= k_s1;
			last_s2               <= last_s1;
			out_word_q.cell_value <= value_d;
			out_word_q.obs_index  <= k_s2;
			out_word_q.last       <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`RWE_ASSERT_RST(a_no_write_over_read, clk, arst_n, mem_we |-> !valid_s1, "memory write while a window read is pending")
	`RWE_ASSERT_RST(a_clear_pipe_empty, clk, arst_n, cmd.clr_step |-> (!valid_s1 && !valid_s2 && !out_valid_q), "clearing pass with words in flight")
	`RWE_ASSERT_RST(a_window_restart, clk, arst_n, (out_valid_q && out_ready && out_word_q.last) |=> (!out_valid_q || (out_word_q.obs_index == 6'd0)), "window does not restart at index zero")

endmodule

@@ rtl/rotated_window_extract_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_window_extract_core
// grid of cell bytes with single-cell writes and rotated square window reads
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// in        to core    in_valid / in_ready     in_word   (rwe_pkg::in_word_t)
// out       from core  out_valid / out_ready   out_word  (rwe_pkg::out_word_t)
// cfg       to core    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// an observe word issues one grid read per cycle, while the out word is not
// stalled, from the single-port grid memory, S*S reads for S = 2R+1 (49 at
// R = 3), each staged through the address, read and output registers
// after reset a clearing pass writes space to all MAX_ROWS*MAX_COLS cells
// (4096 by default), during which in_ready stays low; cfg is always taken
// a stalled out word freezes the whole read pipeline; in_ready also waits for
// a pending read of the previous window to reach the memory
//
module rotated_window_extract_core #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_RADIUS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rwe_pkg::in_word_t              in_word,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output rwe_pkg::out_word_t             out_word,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rwe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rwe_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// register file: map size, radius, output mode and fill code
	rwe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer owns the input handshake and the memory port schedule
	rwe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_word.req_type),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// grid memory, scan counters, read pipeline and output register
	rwe_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.cfg       (cfg),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule
